// ===== design/rsch_pkg.sv =====
// ----------------------------------------------------------------------------
// rsch_pkg: shared types and constants of the ray and sphere hit block
// Holds the sphere entry layout, the item kinds, the status codes, the
// sequencer states and the widths of the internal arithmetic.
// ----------------------------------------------------------------------------
package rsch_pkg;

    localparam int COORD_W    = 32;
    localparam int RAD_W      = 31;
    localparam int MAT_W      = 16;
    localparam int DIR_W      = 18;
    localparam int NORM_W     = 18;
    localparam int IN_DATA_W  = 296;
    localparam int OUT_DATA_W = 168;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 3;

    // Internal arithmetic widths.
    localparam int S_W     = 33;   // origin minus center
    localparam int H_W     = 56;   // dot(dir, s), signed
    localparam int T_W     = 57;   // roots, signed
    localparam int SS_W    = 68;   // |s|^2
    localparam int RR_W    = 62;   // radius^2
    localparam int HH_W    = 106;  // h^2
    localparam int DISC_W  = 108;  // discriminant, Q.64
    localparam int ROOT_W  = 54;   // square root of the discriminant
    localparam int MUL_W   = 64;
    localparam int PROD_W  = 128;
    localparam int OFF_W   = 44;   // offset and unsaturated hit coordinate
    localparam int V_W     = 45;   // hit point minus center
    localparam int DIV_W   = 48;   // divider remainder
    localparam int Q_W     = 17;   // normal quotient before clamping

    localparam logic [Q_W-1:0] NORM_ONE = 17'd65536;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_TRACE = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED  = 3'd0,
        ST_FULL    = 3'd1,
        ST_MISS    = 3'd2,
        ST_HIT     = 3'd3,
        ST_CLEARED = 3'd4
    } status_t;

    typedef struct packed {
        logic [MAT_W-1:0]   mat;
        logic [RAD_W-1:0]   r;
        logic [COORD_W-1:0] cz;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cx;
    } ball_t;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LATCH,
        S_MUL,
        S_CMP,
        S_SQRT,
        S_ROOT,
        S_NEXT,
        S_AXIS,
        S_DSET,
        S_DIV,
        S_NORM,
        S_DONE
    } state_t;

endpackage

// ===== design/rsch_mul.sv =====
// ----------------------------------------------------------------------------
// rsch_mul: sequential 64 by 64 unsigned multiplier
// One 32 by 32 multiplier forms a partial product per cycle; the registered
// partial product is shifted into a 128-bit accumulator in the following cycle.
// ----------------------------------------------------------------------------
module rsch_mul
    import rsch_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mul_req_t          req,
    output logic              done,
    output logic [PROD_W-1:0] prod
);

    logic [2:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [MUL_W-1:0]  a_reg;
    logic [MUL_W-1:0]  b_reg;
    logic [MUL_W-1:0]  pp_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [31:0]       a_half;
    logic [31:0]       b_half;
    logic [2:0]        prev;
    logic [7:0]        shift;

    assign a_half = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign prev   = cnt_reg - 3'd1;
    assign shift  = (prev[1] && prev[0]) ? 8'd64 : ((prev[1] || prev[0]) ? 8'd32 : 8'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd4)
            begin
                pp_reg <= a_half * b_half;
            end
            if (cnt_reg != 3'd0)
            begin
                acc_reg <= acc_reg + (PROD_W'(pp_reg) << shift);
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== design/rsch_sqrt.sv =====
// ----------------------------------------------------------------------------
// rsch_sqrt: floor square root, one result bit per cycle
// Digit-by-digit restoring square root of a 108-bit radicand.
// ----------------------------------------------------------------------------
module rsch_sqrt
    import rsch_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DISC_W-1:0] radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 3;

    logic              busy_reg;
    logic              done_reg;
    logic [5:0]        cnt_reg;
    logic [DISC_W-1:0] x_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    assign rem_sh = {rem_reg[REM_W-3:0], x_reg[DISC_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= x_reg << 2;
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== design/ray_sphere_closest_hit.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit: nearest ray and sphere hit over a sphere table
// Top level: stream ports, sphere memory, trace sequencer and result register.
// ----------------------------------------------------------------------------
// The block keeps up to MAX_SPHERES spheres in a synchronous memory. A load
// word appends a sphere (status loaded, or list full when the table is full),
// a clear word empties the table, and a trace word casts a ray against every
// stored sphere and returns the nearest hit point, the unit normal (pointing
// inward when the origin is inside the sphere) and the material, or a miss.
// A word of kind 3 is consumed without a result. One word is worked on at a
// time. A trace runs every stored sphere through the single shared 32 by 32
// multiplier (eight products per sphere); a sphere that passes the
// discriminant test also goes through the bit-serial square root. The hit
// point and normal are then built with the same multiplier and the
// bit-serial normal divider. The result register lets a new word be
// accepted while the previous result waits on m_tready.
// ----------------------------------------------------------------------------
module ray_sphere_closest_hit
    import rsch_pkg::*;
#(
    parameter int MAX_SPHERES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // center_x, center_y, center_z, sphere_radius, material_tag,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (lowest bit first)
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // kind
    input  logic [KIND_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // hit_x, hit_y, hit_z, normal_x, normal_y, normal_z, hit_material
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status
    output logic [STATUS_W-1:0]   m_tuser
);

    localparam int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CNT_W = $clog2(MAX_SPHERES + 1);

    // Input word fields.
    ball_t            in_ball;
    logic [31:0]      in_o [3];
    logic [DIR_W-1:0] in_d [3];

    assign in_ball.cx  = s_tdata[31:0];
    assign in_ball.cy  = s_tdata[63:32];
    assign in_ball.cz  = s_tdata[95:64];
    assign in_ball.r   = s_tdata[126:96];
    assign in_ball.mat = s_tdata[142:127];
    assign in_o[0]     = s_tdata[174:143];
    assign in_o[1]     = s_tdata[206:175];
    assign in_o[2]     = s_tdata[238:207];
    assign in_d[0]     = s_tdata[256:239];
    assign in_d[1]     = s_tdata[274:257];
    assign in_d[2]     = s_tdata[292:275];

    // Control state.
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             found_reg, found_next;
    logic             m_valid_reg, m_valid_next;
    logic             mul_pend_reg, mul_pend_next;

    // Payload.
    logic [31:0]             o_reg [3];
    logic [DIR_W-1:0]        d_reg [3];
    logic signed [S_W-1:0]   s_reg [3];
    logic signed [H_W-1:0]   h_reg;
    logic [SS_W-1:0]         ss_reg;
    logic [RR_W-1:0]         rr_reg;
    logic [HH_W-1:0]         hh_reg;
    logic                    inside_reg;
    logic [2:0]              op_reg;
    logic signed [T_W-1:0]   best_t_reg;
    ball_t                   best_ball_reg;
    logic                    best_inside_reg;
    logic [1:0]              axis_reg;
    logic signed [V_W-1:0]   v_reg;
    logic [DIV_W-1:0]        rem_reg;
    logic [DIV_W-1:0]        dv_reg;
    logic [Q_W-1:0]          q_reg;
    logic [4:0]              dcnt_reg;
    logic [31:0]             hit_reg [3];
    logic [NORM_W-1:0]       normal_reg [3];
    status_t                 res_status_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic [STATUS_W-1:0]     out_status_reg;

    // Sphere memory.
    ball_t tbl_mem [MAX_SPHERES];
    ball_t rd_reg;
    logic  tbl_we;

    logic accept;
    logic out_free;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign tbl_we   = accept && (kind_t'(s_tuser) == KIND_LOAD)
                      && (count_reg < CNT_W'(MAX_SPHERES));

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[count_reg[IDX_W-1:0]] <= in_ball;
        end
        rd_reg <= tbl_mem[idx_reg[IDX_W-1:0]];
    end

    // Discriminant signals, shared with the square root.
    logic [DISC_W-1:0] lhs;
    logic [DISC_W-1:0] rhs;
    logic [DISC_W-1:0] disc;
    logic              disc_neg;

    // Shared multiplier and square root.
    mul_req_t          mul_req;
    logic              mul_done;
    logic [PROD_W-1:0] mul_p;
    logic              sq_start;
    logic              sq_done;
    logic [ROOT_W-1:0] sq_root;

    rsch_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_p)
    );

    rsch_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (disc),
        .done     (sq_done),
        .root     (sq_root)
    );

    // Operand selection for the per-sphere products.
    logic [1:0]        op_axis;
    logic [DIR_W-1:0]  d_sel;
    logic [S_W-1:0]    s_sel;
    logic [DIR_W-1:0]  d_abs;
    logic [S_W-1:0]    s_abs;
    logic [H_W-1:0]    h_abs;
    logic              prod_neg;
    logic [DIR_W-1:0]  d_ax;
    logic [DIR_W-1:0]  d_ax_abs;
    logic [39:0]       t16;

    always_comb
    begin
        case (op_reg)
            3'd0, 3'd3: op_axis = 2'd0;
            3'd1, 3'd4: op_axis = 2'd1;
            3'd2, 3'd5: op_axis = 2'd2;
            default:    op_axis = 2'd0;
        endcase
    end

    assign d_sel    = d_reg[op_axis];
    assign s_sel    = s_reg[op_axis];
    assign d_abs    = d_sel[DIR_W-1] ? (~d_sel + 1'b1) : d_sel;
    assign s_abs    = s_sel[S_W-1] ? (~s_sel + 1'b1) : s_sel;
    assign h_abs    = h_reg[H_W-1] ? H_W'(-h_reg) : H_W'(h_reg);
    assign prod_neg = d_sel[DIR_W-1] ^ s_sel[S_W-1];
    assign d_ax     = d_reg[axis_reg];
    assign d_ax_abs = d_ax[DIR_W-1] ? (~d_ax + 1'b1) : d_ax;
    assign t16      = best_t_reg[H_W-1:16];

    always_comb
    begin
        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        if (state_reg == S_MUL)
        begin
            mul_req.start = !mul_pend_reg;
            case (op_reg)
                3'd0, 3'd1, 3'd2:
                begin
                    mul_req.a = MUL_W'(d_abs);
                    mul_req.b = MUL_W'(s_abs);
                end
                3'd3, 3'd4, 3'd5:
                begin
                    mul_req.a = MUL_W'(s_abs);
                    mul_req.b = MUL_W'(s_abs);
                end
                3'd6:
                begin
                    mul_req.a = MUL_W'(rd_reg.r);
                    mul_req.b = MUL_W'(rd_reg.r);
                end
                default:
                begin
                    mul_req.a = MUL_W'(h_abs);
                    mul_req.b = MUL_W'(h_abs);
                end
            endcase
        end
        else if (state_reg == S_AXIS)
        begin
            mul_req.start = !mul_pend_reg;
            mul_req.a     = MUL_W'(t16);
            mul_req.b     = MUL_W'(d_ax_abs);
        end
    end

    // Discriminant test: h^2 + r^2 against |s|^2, all in Q.64.
    assign lhs      = DISC_W'(hh_reg) + (DISC_W'(rr_reg) << 32);
    assign rhs      = DISC_W'(ss_reg) << 32;
    assign disc     = lhs - rhs;
    assign disc_neg = lhs < rhs;
    assign sq_start = (state_reg == S_CMP) && !disc_neg;

    // Roots.
    logic signed [T_W-1:0] h_ext;
    logic signed [T_W-1:0] root_ext;
    logic signed [T_W-1:0] t0;
    logic signed [T_W-1:0] t1;
    logic signed [T_W-1:0] t_pick;
    logic                  root_ok;
    logic                  better;

    assign h_ext    = T_W'(h_reg);
    assign root_ext = $signed({3'b000, sq_root});
    assign t0       = -h_ext - root_ext;
    assign t1       = -h_ext + root_ext;
    assign t_pick   = (t0 >= 0) ? t0 : t1;
    assign root_ok  = !(t1 < 0);
    assign better   = !found_reg || (t_pick < best_t_reg);

    // Hit point for one axis: origin + floor(t16 * d / 65536).
    logic [56:0]             off_prod;
    logic [40:0]             off_mag;
    logic signed [OFF_W-1:0] off;
    logic signed [OFF_W-1:0] full;
    logic signed [V_W-1:0]   v_new;
    logic [31:0]             c_ax;
    logic [31:0]             full_sat;

    always_comb
    begin
        case (axis_reg)
            2'd0:    c_ax = best_ball_reg.cx;
            2'd1:    c_ax = best_ball_reg.cy;
            default: c_ax = best_ball_reg.cz;
        endcase
    end

    assign off_prod = mul_p[56:0];
    assign off_mag  = d_ax[DIR_W-1] ? 41'((off_prod + 57'd65535) >> 16) : 41'(off_prod >> 16);
    assign off      = d_ax[DIR_W-1] ? -$signed(OFF_W'(off_mag)) : $signed(OFF_W'(off_mag));
    assign full     = OFF_W'($signed(o_reg[axis_reg])) + off;
    assign v_new    = V_W'(full) - V_W'($signed(c_ax));

    always_comb
    begin
        if (full > OFF_W'(64'sh7FFF_FFFF))
        begin
            full_sat = 32'h7FFF_FFFF;
        end
        else if (full < -OFF_W'(64'sh8000_0000))
        begin
            full_sat = 32'h8000_0000;
        end
        else
        begin
            full_sat = full[31:0];
        end
    end

    // Normal divider setup and result.
    logic [V_W-1:0]   v_abs;
    logic [60:0]      div_num;
    logic             div_sat;
    logic             dv_ge;
    logic [Q_W-1:0]   q_clamp;
    logic [NORM_W-1:0] n_mag;
    logic              n_neg;

    assign v_abs   = v_reg[V_W-1] ? V_W'(-v_reg) : V_W'(v_reg);
    assign div_num = {v_abs[V_W-1:0], 16'd0};
    assign div_sat = div_num >= 61'({best_ball_reg.r, 17'd0});
    assign dv_ge   = rem_reg >= dv_reg;
    assign q_clamp = (q_reg > NORM_ONE) ? NORM_ONE : q_reg;
    assign n_mag   = NORM_W'(q_clamp);
    assign n_neg   = v_reg[V_W-1] ^ best_inside_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (kind_t'(s_tuser))
                        KIND_LOAD, KIND_CLEAR: state_next = S_DONE;
                        KIND_TRACE:            state_next = S_READ;
                        default:               state_next = S_IDLE;
                    endcase
                end
            end
            S_READ:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = found_reg ? S_AXIS : S_DONE;
                end
                else
                begin
                    state_next = S_LATCH;
                end
            end
            S_LATCH: state_next = S_MUL;
            S_MUL:
            begin
                if (mul_done && (op_reg == 3'd7))
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:   state_next = disc_neg ? S_NEXT : S_SQRT;
            S_SQRT:  state_next = sq_done ? S_ROOT : S_SQRT;
            S_ROOT:  state_next = S_NEXT;
            S_NEXT:  state_next = S_READ;
            S_AXIS:  state_next = mul_done ? S_DSET : S_AXIS;
            S_DSET:
            begin
                if ((best_ball_reg.r == '0) || div_sat)
                begin
                    state_next = S_NORM;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:   state_next = (dcnt_reg == 5'd0) ? S_NORM : S_DIV;
            S_NORM:  state_next = (axis_reg == 2'd2) ? S_DONE : S_AXIS;
            S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control register updates.
    always_comb
    begin
        count_next    = count_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        m_valid_next  = m_valid_reg;
        mul_pend_next = mul_pend_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            m_valid_next = 1'b1;
        end
        if (mul_req.start)
        begin
            mul_pend_next = 1'b1;
        end
        else if (mul_done)
        begin
            mul_pend_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (tbl_we)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (kind_t'(s_tuser) == KIND_CLEAR)
                    begin
                        count_next = '0;
                    end
                    idx_next   = '0;
                    found_next = 1'b0;
                end
            end
            S_ROOT:
            begin
                if (root_ok && better)
                begin
                    found_next = 1'b1;
                end
            end
            S_NEXT:  idx_next = idx_reg + 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
            mul_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            found_reg    <= found_next;
            m_valid_reg  <= m_valid_next;
            mul_pend_reg <= mul_pend_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    o_reg    <= in_o;
                    d_reg    <= in_d;
                    axis_reg <= 2'd0;
                    case (kind_t'(s_tuser))
                        KIND_LOAD:  res_status_reg <= tbl_we ? ST_LOADED : ST_FULL;
                        KIND_CLEAR: res_status_reg <= ST_CLEARED;
                        default:    res_status_reg <= ST_MISS;
                    endcase
                end
            end
            S_LATCH:
            begin
                s_reg[0] <= S_W'($signed(o_reg[0])) - S_W'($signed(rd_reg.cx));
                s_reg[1] <= S_W'($signed(o_reg[1])) - S_W'($signed(rd_reg.cy));
                s_reg[2] <= S_W'($signed(o_reg[2])) - S_W'($signed(rd_reg.cz));
                h_reg    <= '0;
                ss_reg   <= '0;
                op_reg   <= 3'd0;
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    op_reg <= op_reg + 3'd1;
                    case (op_reg)
                        3'd0, 3'd1, 3'd2:
                        begin
                            if (prod_neg)
                            begin
                                h_reg <= h_reg - $signed({1'b0, mul_p[H_W-2:0]});
                            end
                            else
                            begin
                                h_reg <= h_reg + $signed({1'b0, mul_p[H_W-2:0]});
                            end
                        end
                        3'd3, 3'd4, 3'd5: ss_reg <= ss_reg + mul_p[SS_W-1:0];
                        3'd6:             rr_reg <= mul_p[RR_W-1:0];
                        default:          hh_reg <= mul_p[HH_W-1:0];
                    endcase
                end
            end
            S_CMP:
            begin
                inside_reg <= ss_reg < SS_W'(rr_reg);
            end
            S_ROOT:
            begin
                if (root_ok && better)
                begin
                    best_t_reg      <= t_pick;
                    best_ball_reg   <= rd_reg;
                    best_inside_reg <= inside_reg;
                end
            end
            S_READ:
            begin
                if ((idx_reg == count_reg) && found_reg)
                begin
                    res_status_reg <= ST_HIT;
                end
            end
            S_AXIS:
            begin
                if (mul_done)
                begin
                    hit_reg[axis_reg] <= full_sat;
                    v_reg             <= v_new;
                end
            end
            S_DSET:
            begin
                rem_reg  <= div_num[DIV_W-1:0];
                dv_reg   <= DIV_W'({best_ball_reg.r, 16'd0});
                dcnt_reg <= 5'd16;
                if (best_ball_reg.r == '0)
                begin
                    q_reg <= '0;
                end
                else if (div_sat)
                begin
                    q_reg <= NORM_ONE;
                end
                else
                begin
                    q_reg <= '0;
                end
            end
            S_DIV:
            begin
                rem_reg  <= dv_ge ? (rem_reg - dv_reg) : rem_reg;
                dv_reg   <= dv_reg >> 1;
                q_reg    <= {q_reg[Q_W-2:0], dv_ge};
                dcnt_reg <= dcnt_reg - 5'd1;
            end
            S_NORM:
            begin
                normal_reg[axis_reg] <= n_neg ? (~n_mag + 1'b1) : n_mag;
                axis_reg             <= axis_reg + 2'd1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_status_reg <= res_status_reg;
                    if (res_status_reg == ST_HIT)
                    begin
                        out_data_reg <= {2'b00, best_ball_reg.mat,
                                         normal_reg[2], normal_reg[1], normal_reg[0],
                                         hit_reg[2], hit_reg[1], hit_reg[0]};
                    end
                    else
                    begin
                        out_data_reg <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    // Checks.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SPHERES))
        else $error("sphere count exceeds the table depth");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind_t'(s_tuser) == KIND_CLEAR)) |=> (count_reg == '0))
        else $error("clear word did not empty the table");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (out_status_reg == ST_MISS)) |-> (out_data_reg == '0))
        else $error("miss result carries a nonzero payload");

    a_mul_owner: assert property (@(posedge clk) disable iff (!rst_n)
        mul_pend_reg |-> ((state_reg == S_MUL) || (state_reg == S_AXIS)))
        else $error("multiplier busy outside the states that use it");

endmodule

// ===== verif/tb_ray_sphere_closest_hit.sv =====
// ----------------------------------------------------------------------------
// tb_ray_sphere_closest_hit: self-checking testbench of the ray and sphere hit block
// Named tests send load, clear, trace and ignored words while the receiver
// idles and stalls at random. A sphere-table model predicts each result word,
// and the predictions are checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_ray_sphere_closest_hit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;
    localparam int IDLE_LIMIT  = 50000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_SHOWN   = 10;

    // One input word, unpacked into its fields.
    typedef struct {
        rsch_pkg::kind_t    kind;
        logic signed [31:0] cx, cy, cz;
        logic [30:0]        radius;
        logic [15:0]        mat;
        logic signed [31:0] ox, oy, oz;
        logic signed [17:0] dx, dy, dz;
    } scene_word_t;

    // One expected or observed result word.
    typedef struct packed {
        rsch_pkg::status_t  status;
        logic signed [31:0] px, py, pz;
        logic signed [17:0] nx, ny, nz;
        logic [15:0]        mat;
    } hit_word_t;

    typedef struct {
        logic signed [31:0] cx, cy, cz;
        logic [30:0]        radius;
        logic [15:0]        mat;
    } sphere_rec_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [rsch_pkg::IN_DATA_W-1:0]       s_tdata;
    logic [rsch_pkg::KIND_W-1:0]          s_tuser;
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [rsch_pkg::OUT_DATA_W-1:0]      m_tdata;
    logic [rsch_pkg::STATUS_W-1:0]        m_tuser;

    // Model state: the sphere table as the block should hold it.
    sphere_rec_t spheres[TABLE_DEPTH];
    int          sphere_total;

    hit_word_t   pending_hits[$];
    int          mismatch_count;
    int          idle_cycles;
    bit          timed_out;
    bit          idle_enable;
    bit          hold_request;
    int          status_seen[5];

    ray_sphere_closest_hit #(.MAX_SPHERES(TABLE_DEPTH)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic logic [63:0] magnitude(longint x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    function automatic longint q16(int whole);
        return longint'(whole) * 65536;
    endfunction

    // Solves t^2 + 2ht + c = 0 for one sphere and returns the nearest
    // non-negative root in Q.32. All sums are kept exact in 128 bits.
    function automatic bit ray_meets(sphere_rec_t sp, longint o[3], longint d[3],
                                     output longint t, output bit is_inside);
        longint      s[3];
        longint      h;
        longint      sq;
        longint      t0;
        longint      t1;
        logic [63:0] hm;
        logic [63:0] root;
        logic [127:0] ss;
        logic [127:0] rr;
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [127:0] disc;
        logic [127:0] cand;
        s[0] = o[0] - longint'(sp.cx);
        s[1] = o[1] - longint'(sp.cy);
        s[2] = o[2] - longint'(sp.cz);
        h = d[0] * s[0] + d[1] * s[1] + d[2] * s[2];
        ss = 0;
        for (int j = 0; j < 3; j++)
            ss += 128'(magnitude(s[j])) * 128'(magnitude(s[j]));
        rr  = 128'(sp.radius) * 128'(sp.radius);
        hm  = magnitude(h);
        lhs = 128'(hm) * 128'(hm) + (rr << 32);
        rhs = ss << 32;
        is_inside = (ss < rr);
        t = 0;
        if (lhs < rhs)
            return 1'b0;
        disc = lhs - rhs;
        root = 0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = 128'(root | (64'd1 << b));
            if (cand * cand <= disc)
                root = cand[63:0];
        end
        sq = longint'(root);
        t0 = -h - sq;
        t1 = -h + sq;
        if (t1 < 0)
            return 1'b0;
        t = (t0 >= 0) ? t0 : t1;
        return 1'b1;
    endfunction

    // Applies one accepted word to the table and works out its result.
    // Returns 0 for the ignored kind, which produces no result.
    function automatic bit predict_hit(scene_word_t w, output hit_word_t res);
        longint o[3];
        longint d[3];
        longint c[3];
        longint t;
        longint best_t;
        longint t16;
        longint off;
        longint full;
        longint v;
        longint nv;
        logic [63:0] q;
        bit     found;
        bit     is_inside;
        int     best;
        longint p[3];
        longint n[3];
        res = '{status: rsch_pkg::ST_MISS, default: '0};
        case (w.kind)
            rsch_pkg::KIND_LOAD:
            begin
                if (sphere_total >= TABLE_DEPTH)
                    res.status = rsch_pkg::ST_FULL;
                else
                begin
                    spheres[sphere_total] = '{w.cx, w.cy, w.cz, w.radius, w.mat};
                    sphere_total++;
                    res.status = rsch_pkg::ST_LOADED;
                end
                return 1'b1;
            end
            rsch_pkg::KIND_CLEAR:
            begin
                sphere_total = 0;
                res.status = rsch_pkg::ST_CLEARED;
                return 1'b1;
            end
            rsch_pkg::KIND_NONE:
                return 1'b0;
            default: ;
        endcase
        o = '{longint'(w.ox), longint'(w.oy), longint'(w.oz)};
        d = '{longint'(w.dx), longint'(w.dy), longint'(w.dz)};
        found = 0;
        best = 0;
        best_t = 0;
        // Strictly-less keeps the earlier sphere on a tie.
        for (int i = 0; i < sphere_total; i++)
            if (ray_meets(spheres[i], o, d, t, is_inside) && (!found || t < best_t))
            begin
                found = 1;
                best_t = t;
                best = i;
            end
        if (!found)
            return 1'b1;
        void'(ray_meets(spheres[best], o, d, t, is_inside));
        c = '{longint'(spheres[best].cx), longint'(spheres[best].cy),
              longint'(spheres[best].cz)};
        t16 = best_t >>> 16;
        for (int j = 0; j < 3; j++)
        begin
            off  = (t16 * d[j]) >>> 16;
            full = o[j] + off;
            v    = full - c[j];
            nv   = 0;
            p[j] = (full > 64'sd2147483647) ? 64'sd2147483647 :
                   (full < -64'sd2147483648) ? -64'sd2147483648 : full;
            if (spheres[best].radius != 0)
            begin
                q = (magnitude(v) << 16) / 64'(spheres[best].radius);
                if (q > 64'd65536)
                    q = 64'd65536;
                nv = longint'(q);
                if (v < 0)
                    nv = -nv;
                if (is_inside)
                    nv = -nv;
            end
            n[j] = nv;
        end
        res.status = rsch_pkg::ST_HIT;
        res.px = p[0][31:0];
        res.py = p[1][31:0];
        res.pz = p[2][31:0];
        res.nx = n[0][17:0];
        res.ny = n[1][17:0];
        res.nz = n[2][17:0];
        res.mat = spheres[best].mat;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Mostly back to back, sometimes a short gap, now and then a long one.
    function automatic int gap_length();
        int pick;
        if (!idle_enable)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(scene_word_t w);
        int        gap;
        hit_word_t res;
        gap = gap_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.kind;
        s_tdata  <= {3'b0, w.dz, w.dy, w.dx, w.oz, w.oy, w.ox,
                     w.mat, w.radius, w.cz, w.cy, w.cx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // Valid stays high; the next call either replaces the word or idles.
        if (predict_hit(w, res))
            pending_hits.push_back(res);
    endtask

    function automatic scene_word_t noise_word(rsch_pkg::kind_t kind);
        scene_word_t w;
        w.kind   = kind;
        w.cx     = $urandom;
        w.cy     = $urandom;
        w.cz     = $urandom;
        w.radius = $urandom;
        w.mat    = $urandom;
        w.ox     = $urandom;
        w.oy     = $urandom;
        w.oz     = $urandom;
        w.dx     = $urandom_range(0, 131072) - 65536;
        w.dy     = $urandom_range(0, 131072) - 65536;
        w.dz     = $urandom_range(0, 131072) - 65536;
        return w;
    endfunction

    // Fields that the kind does not use carry random bits.
    task automatic send_load(longint cx, longint cy, longint cz, longint r, int mat);
        scene_word_t w;
        w = noise_word(rsch_pkg::KIND_LOAD);
        w.cx = cx[31:0];
        w.cy = cy[31:0];
        w.cz = cz[31:0];
        w.radius = r[30:0];
        w.mat = mat[15:0];
        send_word(w);
    endtask

    task automatic send_trace(longint ox, longint oy, longint oz,
                              int dx, int dy, int dz);
        scene_word_t w;
        w = noise_word(rsch_pkg::KIND_TRACE);
        w.ox = ox[31:0];
        w.oy = oy[31:0];
        w.oz = oz[31:0];
        w.dx = dx[17:0];
        w.dy = dy[17:0];
        w.dz = dz[17:0];
        send_word(w);
    endtask

    task automatic send_clear();
        send_word(noise_word(rsch_pkg::KIND_CLEAR));
    endtask

    // Aims a ray from a random point at a chosen point, with optional jitter.
    task automatic send_aimed_trace(longint tx, longint ty, longint tz, int jitter);
        longint o[3];
        real    v[3];
        real    len;
        int     d[3];
        o[0] = q16($urandom_range(0, 160)) - q16(80) + $urandom_range(0, 65535);
        o[1] = q16($urandom_range(0, 160)) - q16(80) + $urandom_range(0, 65535);
        o[2] = q16($urandom_range(0, 160)) - q16(80) + $urandom_range(0, 65535);
        v[0] = real'(tx - o[0]);
        v[1] = real'(ty - o[1]);
        v[2] = real'(tz - o[2]);
        len = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
        if (len < 1.0)
        begin
            v = '{1.0, 0.0, 0.0};
            len = 1.0;
        end
        for (int j = 0; j < 3; j++)
        begin
            d[j] = $rtoi(v[j] / len * 65536.0) + $urandom_range(0, 2 * jitter) - jitter;
            if (d[j] > 65536)
                d[j] = 65536;
            if (d[j] < -65536)
                d[j] = -65536;
        end
        send_trace(o[0], o[1], o[2], d[0], d[1], d[2]);
    endtask

    // Waits until every expected result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0 && !timed_out)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------------

    // The receiver idles at random, and on request holds off for a long
    // stretch so that the result register fills and s_tready drops.
    initial
    begin
        int pick;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!idle_enable)
                m_tready <= 1'b1;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    m_tready <= 1'b1;
                else if (pick < 95)
                    m_tready <= 1'b0;
                else
                begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(10, 60)) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        hit_word_t got;
        hit_word_t want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready)
            begin
                got.status = rsch_pkg::status_t'(m_tuser);
                {got.mat, got.nz, got.ny, got.nx, got.pz, got.py, got.px} = m_tdata[165:0];
                if (pending_hits.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("ERROR: unexpected result word, status %0d", m_tuser);
                end
                else
                begin
                    want = pending_hits.pop_front();
                    if (m_tuser < 5)
                        status_seen[m_tuser]++;
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_SHOWN)
                        begin
                            $display("ERROR: result mismatch at %0t", $realtime);
                            $display("  expected st=%0d p=(%0d,%0d,%0d) n=(%0d,%0d,%0d) m=%0d",
                                     want.status, want.px, want.py, want.pz,
                                     want.nx, want.ny, want.nz, want.mat);
                            $display("  actual   st=%0d p=(%0d,%0d,%0d) n=(%0d,%0d,%0d) m=%0d",
                                     got.status, got.px, got.py, got.pz,
                                     got.nx, got.ny, got.nz, got.mat);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        timed_out = 1'b1;
        $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // A trace on an empty table misses, and a word of the unused kind is
    // swallowed without a result.
    task automatic test_empty_and_ignored();
        send_clear();
        send_trace(0, 0, 0, 65536, 0, 0);
        send_word(noise_word(rsch_pkg::KIND_NONE));
        send_trace(q16(5), 0, 0, 0, -65536, 0);
        drain();
    endtask

    // The seventeenth load reports a full table and changes nothing.
    task automatic test_table_full();
        send_clear();
        for (int i = 0; i < TABLE_DEPTH + 1; i++)
            send_load(q16(4 * i), q16(3), 0, q16(1), 100 + i);
        send_trace(q16(-10), q16(3), 0, 65536, 0, 0);
        drain();
    endtask

    // Tangent ray, zero radius, origin inside, equal spheres, non-unit direction, sphere behind.
    task automatic test_special_shapes();
        send_clear();
        send_load(0, q16(5), 0, q16(5), 11);       // grazed by a ray along x
        send_trace(q16(-10), 0, 0, 65536, 0, 0);
        send_clear();
        send_load(q16(3), 0, 0, 0, 12);            // a point sphere
        send_trace(0, 0, 0, 65536, 0, 0);
        send_clear();
        send_load(0, 0, 0, q16(10), 13);           // origin inside
        send_load(0, 0, 0, q16(10), 14);           // same sphere, loses the tie
        send_trace(0, 0, 0, 0, 65536, 0);
        send_trace(q16(2), q16(1), 0, 65536, 65536, 0);  // direction not unit
        send_trace(q16(20), 0, 0, 65536, 0, 0);    // sphere behind the ray
        drain();
    endtask

    // Extreme coordinates, radius and directions, including a saturated hit.
    task automatic test_extremes();
        send_clear();
        send_load(q16(16384), 0, 0, 64'h7FFFFFFF, 16'hFFFF);
        send_load(64'hFFFFFFFF80000000, 64'h7FFFFFFF, 64'hFFFFFFFF80000000,
                  64'h7FFFFFFF, 0);
        send_trace(0, 0, 0, 65536, 0, 0);
        send_trace(64'h7FFFFFFF, 64'hFFFFFFFF80000000, 64'h7FFFFFFF,
                   -65536, 65536, -65536);
        send_trace(64'hFFFFFFFF80000000, 0, 0, 65536, 0, 0);
        drain();
    endtask

    // Random scenes: mostly a few small spheres and rays aimed at them,
    // sometimes a full table, with noise words mixed in.
    task automatic test_random_scenes(int word_budget);
        int sent;
        int balls;
        int target;
        sent = 0;
        while (sent < word_budget)
        begin
            idle_enable = ($urandom_range(0, 4) != 0);
            send_clear();
            balls = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) :
                    $urandom_range(1, 4);
            for (int i = 0; i < balls; i++)
                send_load(q16($urandom_range(0, 100)) - q16(50) + $urandom_range(0, 65535),
                          q16($urandom_range(0, 100)) - q16(50) + $urandom_range(0, 65535),
                          q16($urandom_range(0, 100)) - q16(50) + $urandom_range(0, 65535),
                          $urandom_range(0, q16(20)), $urandom);
            sent += balls + 1;
            for (int k = 0; k < $urandom_range(3, 8); k++)
            begin
                target = $urandom_range(0, (sphere_total > 0 ? sphere_total : 1) - 1);
                case ($urandom_range(0, 9))
                    0: send_word(noise_word(rsch_pkg::KIND_TRACE));
                    1: send_word(noise_word(rsch_pkg::KIND_NONE));
                    2: send_word(noise_word(rsch_pkg::KIND_LOAD));
                    default:
                        send_aimed_trace(spheres[target].cx, spheres[target].cy,
                                         spheres[target].cz, $urandom_range(0, 3) * 2000);
                endcase
                sent++;
            end
        end
        idle_enable = 1'b1;
        drain();
    endtask

    // The receiver holds off while traces keep coming, so the block stalls.
    task automatic test_backpressure();
        send_clear();
        send_load(0, 0, q16(8), q16(2), 77);
        drain();
        hold_request = 1'b1;
        for (int i = 0; i < 8; i++)
            send_aimed_trace(0, 0, q16(8), 500);
        drain();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        sphere_total = 0;
        mismatch_count = 0;
        idle_cycles  = 0;
        timed_out    = 1'b0;
        hold_request = 1'b0;
        idle_enable  = 1'b1;
        status_seen  = '{default: 0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_ignored();
        test_table_full();
        test_special_shapes();
        test_extremes();
        test_backpressure();
        test_random_scenes(400);

        repeat (300) @(posedge clk);
        $display("Covered %0d loads, %0d full, %0d misses, %0d hits, %0d clears.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        $display("Directed cases: tangent, point sphere, inside, tie, saturation, stall.");
        if (mismatch_count == 0 && pending_hits.size() == 0)
            $display("Testbench completed without errors");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     pending_hits.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
